[hdl/rpn_pkg.sv]
// Shared constants, types and helpers for the RPN stack calculator.
package rpn_pkg;

  // Operand stack size and derived widths
  localparam int STACK_DEPTH   = 64;
  localparam int DEPTH_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W        = $clog2(STACK_DEPTH);
  localparam int DATA_W        = 32;
  localparam int DEPTH_FIELD_W = 7;

  // Command queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Divider iteration counter
  localparam int DIV_CNT_W = $clog2(DATA_W);

  // Stream word widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 48;

  // Request kinds
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_OPER = 1'b1;

  // Operator codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_ADD  = 3'd1,
    CMD_SUB  = 3'd2,
    CMD_MUL  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_ONES = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [DATA_W-1:0] value;
  } q_item_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  // Low bits of the entry count as carried in the result word
  function automatic logic [DEPTH_FIELD_W-1:0] depth_field(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W+DEPTH_FIELD_W-1:0] ext;
    begin
      ext = {{DEPTH_FIELD_W{1'b0}}, d};
      return ext[DEPTH_FIELD_W-1:0];
    end
  endfunction

endpackage

[hdl/rpn_stack_calculator.sv]
// Top level of the reverse Polish stack calculator.
//
// Each input word either pushes a signed 32-bit value or applies an operator to the top
// two stack entries (add, subtract, multiply, divide truncating toward zero, any other
// code gives -1); every word yields one result word with the new top of stack (0 when
// empty), the entry count and a status (ok, underflow, overflow, divide by zero; the stack
// is unchanged on error). A two-word command queue decouples input acceptance from
// execution. Once a word reaches the executing stage, a push or an error without a stack
// read completes straight from the idle state; add, subtract, the -1 operator and divide
// by zero wait for the stack RAM read, multiply also for its product register, and divide
// for the 32-step radix-2 divider, its sign fixup and its done register; a result appears
// in the output register on the cycle after it is computed. Integer values wrap at 32
// bits.
module rpn_stack_calculator import rpn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // [0] req_type, [3:1] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] top_value, [38:32] depth,
                                             // [40:39] status, [47:41] zero
);

  logic                     q_valid;
  q_item_t                  q_item;
  logic                     q_pop;
  logic [DATA_W-1:0]        res_top;
  logic [DEPTH_FIELD_W-1:0] res_depth;
  status_t                  res_status;

  rpn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rpn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_top    (res_top),
    .out_depth  (res_depth),
    .out_status (res_status)
  );

  // Pack result fields, zero padding highest and top value lowest
  assign out_tdata = {{(OUT_TDATA_W - DATA_W - DEPTH_FIELD_W - 2){1'b0}},
                      res_status, res_depth, res_top};

endmodule

[hdl/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/rpn_div.sv]
// Radix-2 restoring signed divider, truncating toward zero, one quotient bit per cycle.
module rpn_div import rpn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DATA_W - 1);

  logic                 busy_r, busy_nxt;
  logic                 fix_r, fix_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, quo_r, dv_r;
  logic                 neg_r;

  logic [DATA_W:0]      shifted, diff;
  logic                 ge;
  logic [DATA_W-1:0]    mag_a, mag_b;
  logic                 last;

  // Magnitudes of the operands at start
  assign mag_a = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
  assign mag_b = req.divisor[DATA_W-1]  ? (DATA_W'(0) - req.divisor)  : req.divisor;

  // One trial subtraction per step
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dv_r};
  assign ge      = !diff[DATA_W];
  assign last    = busy_r && (cnt_r == LAST_STEP);

  // Control sequencing: start, iterate, sign fixup, done
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    fix_nxt  = last;
    done_nxt = fix_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fix_r  <= fix_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dv_r  <= mag_b;
      neg_r <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], ge};
    end else if (fix_r && neg_r) begin
      quo_r <= DATA_W'(0) - quo_r;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[hdl/rpn_front.sv]
// Front end: accepts input words, classifies them into commands and queues them.
module rpn_front import rpn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,  // [31:0] value
  input  logic [IN_TUSER_W-1:0] in_tuser,  // [0] req_type, [3:1] op
  output logic                  q_valid,
  output q_item_t               q_item,
  input  logic                  q_pop
);

  q_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                push, pop;
  q_item_t             new_item;

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_item    = mem_r[rd_ptr_r];

  // Classify the incoming word
  always_comb begin
    new_item.value = in_tdata[DATA_W-1:0];
    if (in_tuser[0] == REQ_PUSH) begin
      new_item.cmd = CMD_PUSH;
    end else begin
      case (in_tuser[3:1])
        OP_ADD:  new_item.cmd = CMD_ADD;
        OP_SUB:  new_item.cmd = CMD_SUB;
        OP_MUL:  new_item.cmd = CMD_MUL;
        OP_DIV:  new_item.cmd = CMD_DIV;
        default: new_item.cmd = CMD_ONES;
      endcase
    end
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? (wr_ptr_r + QPTR_W'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop  ? (rd_ptr_r + QPTR_W'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("pop from empty command queue");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue count missed a push");

endmodule

[hdl/rpn_back.sv]
// Back end: executes queued commands on the operand stack and registers the result.
module rpn_back import rpn_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  q_item_t                  q_item,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [DATA_W-1:0]        out_top,
  output logic [DEPTH_FIELD_W-1:0] out_depth,
  output status_t                  out_status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAIT = 4'b0010,
    S_MUL  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [DATA_W-1:0]   tos_r, tos_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [DATA_W-1:0]   prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_top_r, out_top_nxt;
  logic [DEPTH_FIELD_W-1:0] out_depth_r, out_depth_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [DEPTH_W-1:0]  depth_m1, depth_m2;
  logic [DATA_W-1:0]   prod_low;
  logic                out_free;
  logic                fin, op_done;
  logic [DATA_W-1:0]   op_res, res_top;
  logic [DEPTH_W-1:0]  res_depth;
  status_t             res_status;

  // Entries below the top live in RAM; the top is held in tos_r
  rpn_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign depth_m1  = depth_r - DEPTH_W'(1);
  assign depth_m2  = depth_r - DEPTH_W'(2);
  // Low half of the product is all that is kept
  assign prod_low  = ram_rdata * tos_r;
  assign out_free  = !out_valid_r || out_tready;

  // Command sequencer
  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    tos_nxt    = tos_r;
    cmd_nxt    = cmd_r;
    prod_nxt   = prod_r;
    q_pop      = 1'b0;
    fin        = 1'b0;
    op_done    = 1'b0;
    op_res     = '0;
    res_top    = tos_r;
    res_depth  = depth_r;
    res_status = ST_OK;
    ram_we     = 1'b0;
    ram_waddr  = depth_m1[ADDR_W-1:0];
    ram_wdata  = tos_r;
    ram_raddr  = depth_m2[ADDR_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = ram_rdata;
    div_req.divisor  = tos_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.cmd == CMD_PUSH) begin
            fin = 1'b1;
            if (depth_r >= DEPTH_W'(STACK_DEPTH)) begin
              res_status = ST_OVER;
            end else begin
              // old top spills into RAM
              ram_we    = (depth_r != '0);
              tos_nxt   = q_item.value;
              depth_nxt = depth_r + DEPTH_W'(1);
              res_top   = q_item.value;
              res_depth = depth_r + DEPTH_W'(1);
            end
          end else if (depth_r < DEPTH_W'(2)) begin
            fin        = 1'b1;
            res_status = ST_UNDER;
          end else begin
            cmd_nxt   = q_item.cmd;
            state_nxt = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        // ram_rdata holds operand a, tos_r holds b
        case (cmd_r)
          CMD_ADD: begin
            op_done = 1'b1;
            op_res  = ram_rdata + tos_r;
          end
          CMD_SUB: begin
            op_done = 1'b1;
            op_res  = ram_rdata - tos_r;
          end
          CMD_MUL: begin
            prod_nxt  = prod_low;
            state_nxt = S_MUL;
          end
          CMD_DIV: begin
            if (tos_r == '0) begin
              fin        = 1'b1;
              res_status = ST_DIVZ;
              state_nxt  = S_IDLE;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            op_done = 1'b1;
            op_res  = '1;
          end
        endcase
      end
      S_MUL: begin
        op_done = 1'b1;
        op_res  = prod_r;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          op_done = 1'b1;
          op_res  = div_rsp.quotient;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Two operands replaced by one result
    if (op_done) begin
      fin       = 1'b1;
      tos_nxt   = op_res;
      depth_nxt = depth_m1;
      res_top   = op_res;
      res_depth = depth_m1;
      state_nxt = S_IDLE;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_top_nxt    = out_top_r;
    out_depth_nxt  = out_depth_r;
    out_status_nxt = out_status_r;
    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_top_nxt    = (res_depth == '0) ? '0 : res_top;
      out_depth_nxt  = depth_field(res_depth);
      out_status_nxt = res_status;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    cmd_r        <= cmd_nxt;
    prod_r       <= prod_nxt;
    out_top_r    <= out_top_nxt;
    out_depth_r  <= out_depth_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_top    = out_top_r;
  assign out_depth  = out_depth_r;
  assign out_status = out_status_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_operands_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> depth_r >= DEPTH_W'(2))
    else $error("operator in flight with fewer than two entries");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside divide wait");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> tos_r != '0)
    else $error("divider started with zero divisor");

  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> out_free)
    else $error("result overwrote an untaken word");

endmodule
